/* rtl/core/sad_pkg.sv */
// ----------------------------------------------------------------------------
// sad_pkg: shared types and constants for the sphere arc distance core
// Fixed-point limits, CORDIC arctangent table and pipeline sideband structs.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package sad_pkg;

  localparam int COORD_WIDTH_DEF = 32;
  localparam int FIELD_W         = 32;
  localparam int ANG_LIM         = 24;
  localparam int NORM_LIM        = 30;
  localparam int LEN_LIM         = 31;
  localparam int CORDIC_STEPS    = 30;
  localparam int SQRT_STEPS      = 32;
  localparam int STEPS_PER_STAGE = 2;
  localparam int SL_W            = 6;
  localparam int CX_W            = 34;
  localparam int THETA_FRAC      = 30;
  localparam int CFG_IDX_W       = 2;

  localparam logic [31:0] PI_Q30   = 32'd3373259426;
  localparam logic [31:0] DIST_MAX = 32'hFFFF_FFFF;

  localparam logic [CFG_IDX_W-1:0] REG_REF_X = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_REF_Y = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_REF_Z = 2'd2;

  localparam logic [31:0] ATAN_Q30 [CORDIC_STEPS] = '{
    32'd843314857, 32'd497837829, 32'd263043837, 32'd133525159, 32'd67021687,
    32'd33543516,  32'd16775851,  32'd8388437,   32'd4194283,   32'd2097149,
    32'd1048576,   32'd524288,    32'd262144,    32'd131072,    32'd65536,
    32'd32768,     32'd16384,     32'd8192,      32'd4096,      32'd2048,
    32'd1024,      32'd512,       32'd256,       32'd128,       32'd64,
    32'd32,        32'd16,        32'd8,         32'd4,         32'd2
  };

  // sideband through the front end and the square-root pipe
  typedef struct packed {
    logic                deg;
    logic                last;
    logic [SL_W-1:0]     sl;
    logic                dot_neg;
    logic [NORM_LIM-1:0] dot_mag;
  } side_t;

  // sideband through the CORDIC pipe
  typedef struct packed {
    logic            deg;
    logic            last;
    logic [SL_W-1:0] sl;
    logic            dot_neg;
    logic            nz;
    logic [31:0]     lr;
  } cside_t;

endpackage

/* rtl/core/sad_vec_prep.sv */
// ----------------------------------------------------------------------------
// sad_vec_prep: vector front end
// Eight stages: magnitudes and range reduction, cross/dot products, joint
// reduction, and the two sums of squares handed to the root pipe.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sad_vec_prep #(
  parameter int COORD_WIDTH = sad_pkg::COORD_WIDTH_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        adv,
  input  logic                        in_valid,
  input  logic [sad_pkg::FIELD_W-1:0] vertex_x,
  input  logic [sad_pkg::FIELD_W-1:0] vertex_y,
  input  logic [sad_pkg::FIELD_W-1:0] vertex_z,
  input  logic                        last_vertex,
  input  logic [sad_pkg::FIELD_W-1:0] ref_x,
  input  logic [sad_pkg::FIELD_W-1:0] ref_y,
  input  logic [sad_pkg::FIELD_W-1:0] ref_z,
  output logic                        out_valid,
  output logic [63:0]                 len_sq,
  output logic [63:0]                 cross_sq,
  output sad_pkg::side_t              out_side
);

  localparam int CW  = COORD_WIDTH;
  localparam int AW  = sad_pkg::ANG_LIM + 1;
  localparam int PW  = 2 * AW;
  localparam int CDW = PW + 2;
  localparam int LW  = sad_pkg::LEN_LIM;
  localparam int NW  = sad_pkg::NORM_LIM;
  localparam int SW  = sad_pkg::SL_W;

  function automatic logic [6:0] bit_len(input logic [63:0] v);
    logic [6:0] n;
    n = '0;
    for (int i = 0; i < 64; i++) begin
      if (v[i]) n = 7'(i + 1);
    end
    return n;
  endfunction

  // shift that brings every magnitude below 2^lim
  function automatic logic [SW-1:0] red_shift(input logic [63:0] v, input int lim);
    logic [6:0] l;
    l = bit_len(v);
    return (int'(l) > lim) ? SW'(int'(l) - lim) : '0;
  endfunction

  logic [sad_pkg::FIELD_W-1:0] fv [3];
  logic [sad_pkg::FIELD_W-1:0] fr [3];
  logic [CW-1:0] vc [3];
  logic [CW-1:0] rc [3];
  logic [CW-1:0] vm [3];
  logic [CW-1:0] rm [3];

  assign fv[0] = vertex_x;
  assign fv[1] = vertex_y;
  assign fv[2] = vertex_z;
  assign fr[0] = ref_x;
  assign fr[1] = ref_y;
  assign fr[2] = ref_z;

  for (genvar k = 0; k < 3; k++) begin : g_coord
    if (CW <= sad_pkg::FIELD_W) begin : g_trunc
      assign vc[k] = fv[k][CW-1:0];
      assign rc[k] = fr[k][CW-1:0];
    end else begin : g_ext
      assign vc[k] = {{(CW - sad_pkg::FIELD_W){1'b0}}, fv[k]};
      assign rc[k] = {{(CW - sad_pkg::FIELD_W){1'b0}}, fr[k]};
    end
    assign vm[k] = vc[k][CW-1] ? (~vc[k] + 1'b1) : vc[k];
    assign rm[k] = rc[k][CW-1] ? (~rc[k] + 1'b1) : rc[k];
  end

  // stage 1
  logic [CW-1:0]  p1_vm_r [3];
  logic [CW-1:0]  p1_rm_r [3];
  logic [2:0]     p1_vneg_r, p1_rneg_r, p1_vneg_nxt, p1_rneg_nxt;
  logic [SW-1:0]  p1_sv_r, p1_sr_r, p1_sv_nxt, p1_sr_nxt;
  sad_pkg::side_t p1_side_r, p1_side_nxt;
  logic           p1_valid_r;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      p1_vneg_nxt[k] = vc[k][CW-1];
      p1_rneg_nxt[k] = rc[k][CW-1];
    end
    p1_sv_nxt = red_shift(64'(vm[0] | vm[1] | vm[2]), sad_pkg::ANG_LIM);
    p1_sr_nxt = red_shift(64'(rm[0] | rm[1] | rm[2]), sad_pkg::ANG_LIM);
    p1_side_nxt.deg     = (vc[0] == '0 && vc[1] == '0 && vc[2] == '0) ||
                          (rc[0] == '0 && rc[1] == '0 && rc[2] == '0);
    p1_side_nxt.last    = last_vertex;
    p1_side_nxt.sl      = red_shift(64'(rm[0] | rm[1] | rm[2]), sad_pkg::LEN_LIM);
    p1_side_nxt.dot_neg = 1'b0;
    p1_side_nxt.dot_mag = '0;
  end

  // stage 2: reduced vectors
  logic signed [AW-1:0] p2_ra_r [3];
  logic signed [AW-1:0] p2_rb_r [3];
  logic signed [AW-1:0] p2_ra_nxt [3];
  logic signed [AW-1:0] p2_rb_nxt [3];
  logic [LW-1:0]        p2_rl_r [3];
  logic [LW-1:0]        p2_rl_nxt [3];
  sad_pkg::side_t       p2_side_r;
  logic                 p2_valid_r;

  always_comb begin
    logic [63:0]   tv, tr, tl;
    logic [AW-1:0] mv, mr;
    for (int k = 0; k < 3; k++) begin
      tv = 64'(p1_vm_r[k]) >> p1_sv_r;
      tr = 64'(p1_rm_r[k]) >> p1_sr_r;
      tl = 64'(p1_rm_r[k]) >> p1_side_r.sl;
      mv = {1'b0, tv[sad_pkg::ANG_LIM-1:0]};
      mr = {1'b0, tr[sad_pkg::ANG_LIM-1:0]};
      p2_rb_nxt[k] = p1_vneg_r[k] ? -mv : mv;
      p2_ra_nxt[k] = p1_rneg_r[k] ? -mr : mr;
      p2_rl_nxt[k] = tl[LW-1:0];
    end
  end

  // stage 3: products
  logic signed [PW-1:0] p3_pc_r [6];
  logic signed [PW-1:0] p3_pd_r [3];
  logic signed [PW-1:0] p3_pc_nxt [6];
  logic signed [PW-1:0] p3_pd_nxt [3];
  logic [2*LW-1:0]      p3_lq_r [3];
  logic [2*LW-1:0]      p3_lq_nxt [3];
  sad_pkg::side_t       p3_side_r;
  logic                 p3_valid_r;

  always_comb begin
    p3_pc_nxt[0] = p2_ra_r[1] * p2_rb_r[2];
    p3_pc_nxt[1] = p2_ra_r[2] * p2_rb_r[1];
    p3_pc_nxt[2] = p2_ra_r[2] * p2_rb_r[0];
    p3_pc_nxt[3] = p2_ra_r[0] * p2_rb_r[2];
    p3_pc_nxt[4] = p2_ra_r[0] * p2_rb_r[1];
    p3_pc_nxt[5] = p2_ra_r[1] * p2_rb_r[0];
    for (int k = 0; k < 3; k++) begin
      p3_pd_nxt[k] = p2_ra_r[k] * p2_rb_r[k];
      p3_lq_nxt[k] = p2_rl_r[k] * p2_rl_r[k];
    end
  end

  // stage 4: cross components, dot, |R|^2
  logic signed [CDW-1:0] p4_cd_r [4];
  logic signed [CDW-1:0] p4_cd_nxt [4];
  logic [63:0]           p4_lsum_r, p4_lsum_nxt;
  sad_pkg::side_t        p4_side_r;
  logic                  p4_valid_r;

  always_comb begin
    p4_cd_nxt[0] = CDW'(p3_pc_r[0]) - CDW'(p3_pc_r[1]);
    p4_cd_nxt[1] = CDW'(p3_pc_r[2]) - CDW'(p3_pc_r[3]);
    p4_cd_nxt[2] = CDW'(p3_pc_r[4]) - CDW'(p3_pc_r[5]);
    p4_cd_nxt[3] = CDW'(p3_pd_r[0]) + CDW'(p3_pd_r[1]) + CDW'(p3_pd_r[2]);
    p4_lsum_nxt  = 64'(p3_lq_r[0]) + 64'(p3_lq_r[1]) + 64'(p3_lq_r[2]);
  end

  // stage 5: magnitudes and joint shift
  logic [CDW-1:0] p5_cm_r [4];
  logic [CDW-1:0] p5_cm_nxt [4];
  logic [SW-1:0]  p5_sc_r, p5_sc_nxt;
  logic [63:0]    p5_lsum_r;
  sad_pkg::side_t p5_side_r, p5_side_nxt;
  logic           p5_valid_r;

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      p5_cm_nxt[k] = p4_cd_r[k][CDW-1] ? (~p4_cd_r[k] + 1'b1) : p4_cd_r[k];
    end
    p5_sc_nxt = red_shift(64'(p5_cm_nxt[0] | p5_cm_nxt[1] | p5_cm_nxt[2] | p5_cm_nxt[3]),
                          sad_pkg::NORM_LIM);
    p5_side_nxt         = p4_side_r;
    p5_side_nxt.dot_neg = p4_cd_r[3][CDW-1];
  end

  // stage 6: reduced cross/dot magnitudes
  logic [NW-1:0]  p6_rc_r [3];
  logic [NW-1:0]  p6_rc_nxt [3];
  logic [63:0]    p6_lsum_r;
  sad_pkg::side_t p6_side_r, p6_side_nxt;
  logic           p6_valid_r;

  always_comb begin
    logic [63:0] t;
    for (int k = 0; k < 3; k++) begin
      t = 64'(p5_cm_r[k]) >> p5_sc_r;
      p6_rc_nxt[k] = t[NW-1:0];
    end
    t = 64'(p5_cm_r[3]) >> p5_sc_r;
    p6_side_nxt         = p5_side_r;
    p6_side_nxt.dot_mag = t[NW-1:0];
    // a negative dot that reduces to zero counts as non-negative
    p6_side_nxt.dot_neg = p5_side_r.dot_neg && (t[NW-1:0] != '0);
  end

  // stage 7: squares of cross components
  logic [2*NW-1:0] p7_q_r [3];
  logic [2*NW-1:0] p7_q_nxt [3];
  logic [63:0]     p7_lsum_r;
  sad_pkg::side_t  p7_side_r;
  logic            p7_valid_r;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      p7_q_nxt[k] = p6_rc_r[k] * p6_rc_r[k];
    end
  end

  // stage 8: |cross|^2
  logic [63:0]    p8_nsum_r, p8_nsum_nxt;
  logic [63:0]    p8_lsum_r;
  sad_pkg::side_t p8_side_r;
  logic           p8_valid_r;

  assign p8_nsum_nxt = 64'(p7_q_r[0]) + 64'(p7_q_r[1]) + 64'(p7_q_r[2]);

  always_ff @(posedge clk) begin
    if (adv) begin
      p1_vm_r   <= vm;
      p1_rm_r   <= rm;
      p1_vneg_r <= p1_vneg_nxt;
      p1_rneg_r <= p1_rneg_nxt;
      p1_sv_r   <= p1_sv_nxt;
      p1_sr_r   <= p1_sr_nxt;
      p1_side_r <= p1_side_nxt;
      p2_ra_r   <= p2_ra_nxt;
      p2_rb_r   <= p2_rb_nxt;
      p2_rl_r   <= p2_rl_nxt;
      p2_side_r <= p1_side_r;
      p3_pc_r   <= p3_pc_nxt;
      p3_pd_r   <= p3_pd_nxt;
      p3_lq_r   <= p3_lq_nxt;
      p3_side_r <= p2_side_r;
      p4_cd_r   <= p4_cd_nxt;
      p4_lsum_r <= p4_lsum_nxt;
      p4_side_r <= p3_side_r;
      p5_cm_r   <= p5_cm_nxt;
      p5_sc_r   <= p5_sc_nxt;
      p5_lsum_r <= p4_lsum_r;
      p5_side_r <= p5_side_nxt;
      p6_rc_r   <= p6_rc_nxt;
      p6_lsum_r <= p5_lsum_r;
      p6_side_r <= p6_side_nxt;
      p7_q_r    <= p7_q_nxt;
      p7_lsum_r <= p6_lsum_r;
      p7_side_r <= p6_side_r;
      p8_nsum_r <= p8_nsum_nxt;
      p8_lsum_r <= p7_lsum_r;
      p8_side_r <= p7_side_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p1_valid_r <= 1'b0;
      p2_valid_r <= 1'b0;
      p3_valid_r <= 1'b0;
      p4_valid_r <= 1'b0;
      p5_valid_r <= 1'b0;
      p6_valid_r <= 1'b0;
      p7_valid_r <= 1'b0;
      p8_valid_r <= 1'b0;
    end else if (adv) begin
      p1_valid_r <= in_valid;
      p2_valid_r <= p1_valid_r;
      p3_valid_r <= p2_valid_r;
      p4_valid_r <= p3_valid_r;
      p5_valid_r <= p4_valid_r;
      p6_valid_r <= p5_valid_r;
      p7_valid_r <= p6_valid_r;
      p8_valid_r <= p7_valid_r;
    end
  end

  assign out_valid = p8_valid_r;
  assign len_sq    = p8_lsum_r;
  assign cross_sq  = p8_nsum_r;
  assign out_side  = p8_side_r;

endmodule

/* rtl/core/sad_sqrt_pipe.sv */
// ----------------------------------------------------------------------------
// sad_sqrt_pipe: two-lane pipelined integer square root
// Digit-by-digit root of two 64-bit radicands, two digits per stage.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sad_sqrt_pipe (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           adv,
  input  logic           in_valid,
  input  logic [63:0]    rad_a,
  input  logic [63:0]    rad_b,
  input  sad_pkg::side_t in_side,
  output logic           out_valid,
  output logic [31:0]    root_a,
  output logic [31:0]    root_b,
  output sad_pkg::side_t out_side
);

  localparam int SPS = sad_pkg::STEPS_PER_STAGE;
  localparam int NST = sad_pkg::SQRT_STEPS / SPS;

  logic [63:0]    n_r   [NST][2];
  logic [63:0]    res_r [NST][2];
  sad_pkg::side_t s_r   [NST];
  logic           v_r   [NST];

  for (genvar g = 0; g < NST; g++) begin : g_stage
    logic [63:0]    n_src [2];
    logic [63:0]    r_src [2];
    logic [63:0]    n_nxt [2];
    logic [63:0]    r_nxt [2];
    sad_pkg::side_t s_src;
    logic           v_src;

    if (g == 0) begin : g_first
      assign n_src[0] = rad_a;
      assign n_src[1] = rad_b;
      assign r_src[0] = '0;
      assign r_src[1] = '0;
      assign s_src    = in_side;
      assign v_src    = in_valid;
    end else begin : g_next
      assign n_src[0] = n_r[g-1][0];
      assign n_src[1] = n_r[g-1][1];
      assign r_src[0] = res_r[g-1][0];
      assign r_src[1] = res_r[g-1][1];
      assign s_src    = s_r[g-1];
      assign v_src    = v_r[g-1];
    end

    always_comb begin
      logic [63:0] nw, rw, bitv;
      for (int l = 0; l < 2; l++) begin
        nw = n_src[l];
        rw = r_src[l];
        for (int j = 0; j < SPS; j++) begin
          bitv = 64'd1 << (2 * (sad_pkg::SQRT_STEPS - 1 - (g * SPS + j)));
          if (nw >= rw + bitv) begin
            nw = nw - (rw + bitv);
            rw = (rw >> 1) + bitv;
          end else begin
            rw = rw >> 1;
          end
        end
        n_nxt[l] = nw;
        r_nxt[l] = rw;
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        n_r[g]   <= n_nxt;
        res_r[g] <= r_nxt;
        s_r[g]   <= s_src;
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[g] <= 1'b0;
      end else if (adv) begin
        v_r[g] <= v_src;
      end
    end
  end

  assign out_valid = v_r[NST-1];
  assign root_a    = res_r[NST-1][0][31:0];
  assign root_b    = res_r[NST-1][1][31:0];
  assign out_side  = s_r[NST-1];

endmodule

/* rtl/core/sad_cordic_pipe.sv */
// ----------------------------------------------------------------------------
// sad_cordic_pipe: vectoring CORDIC, atan2(y, x) in Q2.30 radians
// Thirty micro-rotations, two per stage.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sad_cordic_pipe (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          adv,
  input  logic                          in_valid,
  input  logic [sad_pkg::NORM_LIM-1:0]  x_in,
  input  logic [31:0]                   y_in,
  input  sad_pkg::cside_t               in_side,
  output logic                          out_valid,
  output logic signed [sad_pkg::CX_W-1:0] z_out,
  output sad_pkg::cside_t               out_side
);

  localparam int XW  = sad_pkg::CX_W;
  localparam int SPS = sad_pkg::STEPS_PER_STAGE;
  localparam int NST = sad_pkg::CORDIC_STEPS / SPS;

  logic signed [XW-1:0] x_r [NST];
  logic signed [XW-1:0] y_r [NST];
  logic signed [XW-1:0] z_r [NST];
  sad_pkg::cside_t      s_r [NST];
  logic                 v_r [NST];

  for (genvar g = 0; g < NST; g++) begin : g_stage
    logic signed [XW-1:0] x_src, y_src, z_src, x_nxt, y_nxt, z_nxt;
    sad_pkg::cside_t      s_src;
    logic                 v_src;

    if (g == 0) begin : g_first
      assign x_src = XW'(x_in);
      assign y_src = XW'(y_in);
      assign z_src = '0;
      assign s_src = in_side;
      assign v_src = in_valid;
    end else begin : g_next
      assign x_src = x_r[g-1];
      assign y_src = y_r[g-1];
      assign z_src = z_r[g-1];
      assign s_src = s_r[g-1];
      assign v_src = v_r[g-1];
    end

    always_comb begin
      logic signed [XW-1:0] xw, yw, zw, xs, ys, at;
      xw = x_src;
      yw = y_src;
      zw = z_src;
      for (int j = 0; j < SPS; j++) begin
        xs = xw >>> (g * SPS + j);
        ys = yw >>> (g * SPS + j);
        at = XW'(sad_pkg::ATAN_Q30[g * SPS + j]);
        if (!yw[XW-1] && (yw != '0)) begin
          xw = xw + ys;
          yw = yw - xs;
          zw = zw + at;
        end else begin
          xw = xw - ys;
          yw = yw + xs;
          zw = zw - at;
        end
      end
      x_nxt = xw;
      y_nxt = yw;
      z_nxt = zw;
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        x_r[g] <= x_nxt;
        y_r[g] <= y_nxt;
        z_r[g] <= z_nxt;
        s_r[g] <= s_src;
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[g] <= 1'b0;
      end else if (adv) begin
        v_r[g] <= v_src;
      end
    end
  end

  assign out_valid = v_r[NST-1];
  assign z_out     = z_r[NST-1];
  assign out_side  = s_r[NST-1];

endmodule

/* rtl/core/sphere_arc_distance_core.sv */
// ----------------------------------------------------------------------------
// sphere_arc_distance_core: great-circle distance of vertices to a reference
// Streams vertex positions and returns |R| * angle(R, V), Q16.16, saturated.
// ----------------------------------------------------------------------------
//
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+-------------------------------
//  in_     | sink      | in_valid / in_stall  | vertex_x/y/z, last_vertex
//  out_    | source    | out_valid / out_stall| arc_distance, degenerate,
//          |           |                      | last_result
//  cfg_    | sink      | cfg_we (no wait)     | cfg_index, cfg_data
//
//  One transaction per cycle sustained while the pipe is not frozen; 42
//  register stages in all: 8 front-end stages, 16 root stages, 15 CORDIC
//  stages, clamp, multiply and the output register.
//  Synchronous active-low reset clears valid bits and reference registers.
//  The pipe freezes only when the output register holds an untaken result
//  and the last pipe stage is also full; bubbles keep filling otherwise.
//
// Datapath:
//  - |R| from the reference reduced below 2^31 (shift sl), then sqrt.
//  - Angle = atan2(|R x V|, R . V) on vectors reduced below 2^24, with
//    cross/dot reduced jointly below 2^30; pi - z for negative dot.
//  - Distance = Lr * theta >> (30 - sl), saturated to 32 bits.
//  - Zero reference or zero vertex: distance 0, degenerate set.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sphere_arc_distance_core #(
  parameter int COORD_WIDTH = sad_pkg::COORD_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  // vertex input
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [sad_pkg::FIELD_W-1:0]   in_vertex_x,
  input  logic [sad_pkg::FIELD_W-1:0]   in_vertex_y,
  input  logic [sad_pkg::FIELD_W-1:0]   in_vertex_z,
  input  logic                          in_last_vertex,
  // result output
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [31:0]                   out_arc_distance,
  output logic                          out_degenerate,
  output logic                          out_last_result,
  // configuration
  input  logic                          cfg_we,
  input  logic [sad_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [sad_pkg::FIELD_W-1:0]   cfg_data
);

  localparam int SW = sad_pkg::SL_W;
  localparam int XW = sad_pkg::CX_W;

  // reference point registers
  logic [sad_pkg::FIELD_W-1:0] ref_x_r, ref_y_r, ref_z_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ref_x_r <= '0;
      ref_y_r <= '0;
      ref_z_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        sad_pkg::REG_REF_X: ref_x_r <= cfg_data;
        sad_pkg::REG_REF_Y: ref_y_r <= cfg_data;
        sad_pkg::REG_REF_Z: ref_z_r <= cfg_data;
        default: ;  // unmapped index: write dropped
      endcase
    end
  end

  // global advance: hold only when output is stuck and the last stage is full
  logic adv;
  logic out_valid_r;
  logic f2_valid_r;

  assign adv      = !(out_valid_r && out_stall && f2_valid_r);
  assign in_stall = !adv;

  // front end
  logic           fe_valid;
  logic [63:0]    fe_len_sq, fe_cross_sq;
  sad_pkg::side_t fe_side;

  sad_vec_prep #(
    .COORD_WIDTH (COORD_WIDTH)
  ) u_prep (
    .clk         (clk),
    .rst_n       (rst_n),
    .adv         (adv),
    .in_valid    (in_valid),
    .vertex_x    (in_vertex_x),
    .vertex_y    (in_vertex_y),
    .vertex_z    (in_vertex_z),
    .last_vertex (in_last_vertex),
    .ref_x       (ref_x_r),
    .ref_y       (ref_y_r),
    .ref_z       (ref_z_r),
    .out_valid   (fe_valid),
    .len_sq      (fe_len_sq),
    .cross_sq    (fe_cross_sq),
    .out_side    (fe_side)
  );

  // square roots: lane a = |R| (reduced), lane b = |cross|
  logic           sq_valid;
  logic [31:0]    sq_lr, sq_nrm;
  sad_pkg::side_t sq_side;

  sad_sqrt_pipe u_sqrt (
    .clk       (clk),
    .rst_n     (rst_n),
    .adv       (adv),
    .in_valid  (fe_valid),
    .rad_a     (fe_len_sq),
    .rad_b     (fe_cross_sq),
    .in_side   (fe_side),
    .out_valid (sq_valid),
    .root_a    (sq_lr),
    .root_b    (sq_nrm),
    .out_side  (sq_side)
  );

  sad_pkg::cside_t cd_in_side;

  always_comb begin
    cd_in_side.deg     = sq_side.deg;
    cd_in_side.last    = sq_side.last;
    cd_in_side.sl      = sq_side.sl;
    cd_in_side.dot_neg = sq_side.dot_neg;
    cd_in_side.nz      = (sq_nrm != '0);
    cd_in_side.lr      = sq_lr;
  end

  // angle
  logic                 cd_valid;
  logic signed [XW-1:0] cd_z;
  sad_pkg::cside_t      cd_side;

  sad_cordic_pipe u_cordic (
    .clk       (clk),
    .rst_n     (rst_n),
    .adv       (adv),
    .in_valid  (sq_valid),
    .x_in      (sq_side.dot_mag),
    .y_in      (sq_nrm),
    .in_side   (cd_in_side),
    .out_valid (cd_valid),
    .z_out     (cd_z),
    .out_side  (cd_side)
  );

  // F1: clamp to [0, pi], fold for negative dot
  logic [31:0]   f1_th_r, f1_th_nxt, f1_lr_r;
  logic [SW-1:0] f1_sl_r;
  logic          f1_deg_r, f1_last_r, f1_valid_r;

  always_comb begin
    logic signed [XW-1:0] pi_s;
    logic [31:0]          zc;
    pi_s = $signed(XW'(sad_pkg::PI_Q30));
    if (!cd_side.nz || cd_z[XW-1]) begin
      zc = '0;
    end else if (cd_z > pi_s) begin
      zc = sad_pkg::PI_Q30;
    end else begin
      zc = cd_z[31:0];
    end
    f1_th_nxt = cd_side.dot_neg ? (sad_pkg::PI_Q30 - zc) : zc;
  end

  // F2: Lr * theta
  logic [63:0]   f2_prod_r, f2_prod_nxt;
  logic [SW-1:0] f2_sl_r;
  logic          f2_deg_r, f2_last_r;

  assign f2_prod_nxt = 64'(f1_lr_r) * 64'(f1_th_r);

  // F3: scale and saturate into the output register
  logic [31:0] out_dist_r, out_dist_nxt;
  logic        out_deg_r, out_last_r;
  logic        out_load;

  assign out_load = !out_valid_r || !out_stall;

  always_comb begin
    logic [63:0] sh;
    sh = f2_prod_r >> (SW'(sad_pkg::THETA_FRAC) - f2_sl_r);
    if (f2_deg_r) begin
      out_dist_nxt = '0;
    end else if (f2_sl_r > SW'(sad_pkg::THETA_FRAC)) begin
      out_dist_nxt = (f2_prod_r != '0) ? sad_pkg::DIST_MAX : '0;
    end else if (sh[63:32] != '0) begin
      out_dist_nxt = sad_pkg::DIST_MAX;
    end else begin
      out_dist_nxt = sh[31:0];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      f1_th_r   <= f1_th_nxt;
      f1_lr_r   <= cd_side.lr;
      f1_sl_r   <= cd_side.sl;
      f1_deg_r  <= cd_side.deg;
      f1_last_r <= cd_side.last;
      f2_prod_r <= f2_prod_nxt;
      f2_sl_r   <= f1_sl_r;
      f2_deg_r  <= f1_deg_r;
      f2_last_r <= f1_last_r;
    end
    if (out_load) begin
      out_dist_r <= out_dist_nxt;
      out_deg_r  <= f2_deg_r;
      out_last_r <= f2_last_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f1_valid_r  <= 1'b0;
      f2_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (adv) begin
        f1_valid_r <= cd_valid;
        f2_valid_r <= f1_valid_r;
      end
      if (out_load) begin
        out_valid_r <= f2_valid_r;
      end
    end
  end

  assign out_valid        = out_valid_r;
  assign out_arc_distance = out_dist_r;
  assign out_degenerate   = out_deg_r;
  assign out_last_result  = out_last_r;

  // input stalls only behind a blocked result
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (out_valid && out_stall))
    else $error("input stalled while output not blocked");

  // folded angle never exceeds pi
  a_theta_range: assert property (@(posedge clk) disable iff (!rst_n)
    f1_valid_r |-> (f1_th_r <= sad_pkg::PI_Q30))
    else $error("angle out of range");

  // taken result with nothing behind it leaves the output empty
  a_no_repeat: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_stall && !f2_valid_r) |=> !out_valid_r)
    else $error("result transaction repeated");

endmodule

/* tb/sphere_arc_distance_core_test.sv */
// ----------------------------------------------------------------------------
// sphere_arc_distance_core_test: self-checking bench for the arc distance core
// Streams vertices under several reference points and compares every result
// with a bit-exact fixed-point arc distance computed inside the bench.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sphere_arc_distance_core_test;

  localparam int HOLD_CYCLES = 400;   // long receiver hold-off
  localparam int DRAIN_WAIT  = 60;    // extra wait for the pipe to empty
  localparam int WDOG_LIMIT  = 5000;
  localparam longint PI_FIX  = 64'd3373259426;
  localparam logic [sad_pkg::CFG_IDX_W-1:0] REG_UNMAPPED = 2'd3;

  // arctangent table, Q2.30 radians
  localparam longint ATAN_TBL [30] = '{
    843314857, 497837829, 263043837, 133525159, 67021687, 33543516,
    16775851, 8388437, 4194283, 2097149, 1048576, 524288, 262144, 131072,
    65536, 32768, 16384, 8192, 4096, 2048, 1024, 512, 256, 128, 64, 32,
    16, 8, 4, 2
  };

  typedef struct {
    logic [31:0] x, y, z;
    logic        last;
  } vertex_t;

  typedef struct {
    logic [31:0] arc_dist;
    logic        deg;
    logic        last;
  } arc_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [31:0] in_vertex_x = '0, in_vertex_y = '0, in_vertex_z = '0;
  logic        in_last_vertex = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [31:0] out_arc_distance;
  logic        out_degenerate, out_last_result;
  logic        cfg_we = 1'b0;
  logic [sad_pkg::CFG_IDX_W-1:0] cfg_index = sad_pkg::REG_REF_X;
  logic [31:0] cfg_data = '0;

  vertex_t     vertex_q[$];
  arc_t        arc_q[$];
  logic [31:0] ref_pt [3];     // bench copy of the reference registers
  int          send_idle = 0;  // percent of cycles the sender idles
  int          recv_idle = 0;  // percent of cycles the receiver stalls
  bit          hold_req  = 0;
  int          hold_left = 0;
  int          errors = 0, n_sent = 0, n_recv = 0, n_deg = 0, n_sat = 0;
  int          quiet = 0;

  sphere_arc_distance_core DUT (.*);

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Fixed-point arc distance predictor
  // ---------------------------------------------------------------------------
  function automatic longint unsigned mag(longint v);
    return v < 0 ? longint'(0) - v : v;
  endfunction

  // shift magnitudes right (sign kept) until all fit below 2^lim
  function automatic int shrink(input longint a[4], output longint o[4],
                                input int n, input int lim);
    longint unsigned mx = 0;
    longint unsigned m;
    int s = 0;
    for (int i = 0; i < n; i++) if (mag(a[i]) > mx) mx = mag(a[i]);
    while (((mx >> s) >> lim) != 0) s++;
    for (int i = 0; i < 4; i++) begin
      m = mag(a[i]) >> s;
      o[i] = (i < n && a[i] < 0) ? -longint'(m) : longint'(m);
    end
    return s;
  endfunction

  function automatic longint unsigned isqrt(longint unsigned n);
    longint unsigned res = 0;
    longint unsigned b = 64'd1 << 62;
    while (b > n) b >>= 2;
    while (b != 0) begin
      if (n >= res + b) begin
        n -= res + b;
        res = (res >> 1) + b;
      end else begin
        res >>= 1;
      end
      b >>= 2;
    end
    return res;
  endfunction

  function automatic longint unsigned sq3(longint a[4]);
    return mag(a[0]) * mag(a[0]) + mag(a[1]) * mag(a[1]) + mag(a[2]) * mag(a[2]);
  endfunction

  // angle between r and v, Q2.30 radians, both nonzero
  function automatic longint angle_between(longint r[4], longint v[4]);
    longint ra[4], rv[4], cd[4], rc[4];
    longint x, y, z, xs, ys, th;
    longint unsigned nrm;
    int s;
    s = shrink(r, ra, 3, sad_pkg::ANG_LIM);
    s = shrink(v, rv, 3, sad_pkg::ANG_LIM);
    cd[0] = ra[1] * rv[2] - ra[2] * rv[1];
    cd[1] = ra[2] * rv[0] - ra[0] * rv[2];
    cd[2] = ra[0] * rv[1] - ra[1] * rv[0];
    cd[3] = ra[0] * rv[0] + ra[1] * rv[1] + ra[2] * rv[2];
    s = shrink(cd, rc, 4, sad_pkg::NORM_LIM);
    nrm = isqrt(sq3(rc));
    z = 0;
    if (nrm != 0) begin
      x = mag(rc[3]);
      y = nrm;
      for (int i = 0; i < 30; i++) begin
        xs = x >>> i;
        ys = y >>> i;
        if (y > 0) begin
          x += ys; y -= xs; z += ATAN_TBL[i];
        end else begin
          x -= ys; y += xs; z -= ATAN_TBL[i];
        end
      end
      if (z < 0) z = 0;
      if (z > PI_FIX) z = PI_FIX;
    end
    th = rc[3] < 0 ? PI_FIX - z : z;
    return th < 0 ? 0 : th;
  endfunction

  function automatic arc_t arc_distance(logic [31:0] rx, ry, rz, vertex_t vt);
    arc_t   a;
    longint r[4], v[4], rl[4];
    longint th;
    longint unsigned lr, prod, d;
    int sl;
    r = '{longint'($signed(rx)), longint'($signed(ry)), longint'($signed(rz)), 0};
    v = '{longint'($signed(vt.x)), longint'($signed(vt.y)), longint'($signed(vt.z)), 0};
    a.last     = vt.last;
    a.arc_dist = '0;
    a.deg      = 1'b0;
    if ((r[0] == 0 && r[1] == 0 && r[2] == 0) || (v[0] == 0 && v[1] == 0 && v[2] == 0)) begin
      a.deg = 1'b1;
    end else begin
      th   = angle_between(r, v);
      sl   = shrink(r, rl, 3, sad_pkg::LEN_LIM);
      lr   = isqrt(sq3(rl));
      prod = lr * longint'(th);
      if (sl <= 30) d = prod >> (30 - sl);
      else d = prod != 0 ? 64'hFFFF_FFFF : 0;
      a.arc_dist = d > 64'hFFFF_FFFF ? sad_pkg::DIST_MAX : d[31:0];
    end
    return a;
  endfunction

  // ---------------------------------------------------------------------------
  // Driver: presents queued vertices, predicts on each accepted transaction
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    vertex_t vt;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        vt = '{in_vertex_x, in_vertex_y, in_vertex_z, in_last_vertex};
        arc_q.push_back(arc_distance(ref_pt[0], ref_pt[1], ref_pt[2], vt));
        n_sent++;
      end
      // payload only moves once the current transaction is gone
      if (!in_valid || !in_stall) begin
        if (vertex_q.size() > 0 && $urandom_range(99) >= send_idle) begin
          vt = vertex_q.pop_front();
          in_vertex_x    <= vt.x;
          in_vertex_y    <= vt.y;
          in_vertex_z    <= vt.z;
          in_last_vertex <= vt.last;
          in_valid       <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: random stalls, long hold-off on request, field-by-field compare
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    arc_t e;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        n_recv++;
        if (arc_q.size() == 0) begin
          errors++;
          $display("%0t: unexpected result dist=%h deg=%b last=%b", $time,
                   out_arc_distance, out_degenerate, out_last_result);
        end else begin
          e = arc_q.pop_front();
          if (e.deg) n_deg++;
          if (e.arc_dist == sad_pkg::DIST_MAX) n_sat++;
          if (out_arc_distance !== e.arc_dist) begin
            errors++;
            $display("%0t: arc_distance expected %h actual %h", $time, e.arc_dist,
                     out_arc_distance);
          end
          if (out_degenerate !== e.deg) begin
            errors++;
            $display("%0t: degenerate expected %b actual %b", $time, e.deg,
                     out_degenerate);
          end
          if (out_last_result !== e.last) begin
            errors++;
            $display("%0t: last_result expected %b actual %b", $time, e.last,
                     out_last_result);
          end
        end
      end
      if (hold_req && hold_left == 0) hold_left = HOLD_CYCLES;
      if (hold_left > 0) begin
        hold_left--;
        if (hold_left == 0) hold_req = 0;
        out_stall <= 1'b1;
      end else begin
        out_stall <= ($urandom_range(99) < recv_idle);
      end
    end
  end

  // watchdog: cycles in which neither channel moves
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet <= 0;
    else quiet <= quiet + 1;
    if (quiet >= WDOG_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  task automatic write_reg(logic [sad_pkg::CFG_IDX_W-1:0] idx, logic [31:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    if (idx == sad_pkg::REG_REF_X) ref_pt[0] = val;
    else if (idx == sad_pkg::REG_REF_Y) ref_pt[1] = val;
    else if (idx == sad_pkg::REG_REF_Z) ref_pt[2] = val;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic set_ref(logic [31:0] x, y, z);
    write_reg(sad_pkg::REG_REF_X, x);
    write_reg(sad_pkg::REG_REF_Y, y);
    write_reg(sad_pkg::REG_REF_Z, z);
  endtask

  task automatic queue_vertex(logic [31:0] x, y, z, logic last);
    vertex_q.push_back('{x, y, z, last});
  endtask

  // wait until every transaction is back and the pipe has emptied
  task automatic drain();
    while (vertex_q.size() != 0 || arc_q.size() != 0 || in_valid) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  function automatic logic [31:0] rand_coord();
    logic [31:0] c;
    case ($urandom_range(3))
      0: c = $urandom;                                   // full range
      1: c = $signed($urandom) >>> $urandom_range(31);   // mixed magnitudes
      2: c = $urandom_range(1) ? 32'h7FFF_FFFF : 32'h8000_0000;
      default: c = $urandom_range(3) - 1;                // -1 .. 2
    endcase
    return c;
  endfunction

  // a vertex along or against the reference, the zero vertex, or anywhere
  task automatic queue_random();
    logic [31:0] vx, vy, vz;
    int k;
    case ($urandom_range(9))
      0, 1: begin
        k  = $urandom_range(8);
        vx = $signed(ref_pt[0]) >>> k;
        vy = $signed(ref_pt[1]) >>> k;
        vz = $signed(ref_pt[2]) >>> k;
        if ($urandom_range(1)) begin
          vx = -vx; vy = -vy; vz = -vz;
        end
        vx ^= $urandom_range(1);   // nudge slightly off the axis
      end
      2: begin
        vx = 0; vy = 0; vz = 0;
      end
      default: begin
        vx = rand_coord(); vy = rand_coord(); vz = rand_coord();
      end
    endcase
    queue_vertex(vx, vy, vz, $urandom_range(1));
  endtask

  initial begin
    logic [31:0] rx, ry, rz;
    ref_pt = '{default: '0};
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // zero reference after reset: everything degenerate
    queue_vertex(32'h0001_0000, 0, 0, 1'b0);
    queue_vertex(32'h7FFF_FFFF, 32'h8000_0000, 1, 1'b1);
    drain();

    // unit x reference: directed angles and field extremes
    set_ref(32'h0001_0000, 0, 0);
    queue_vertex(0, 0, 0, 1'b1);                      // zero vertex
    queue_vertex(32'h0002_0000, 0, 0, 1'b0);          // same direction
    queue_vertex(32'hFFFF_0000, 0, 0, 1'b1);          // opposite direction
    queue_vertex(0, 32'h0001_0000, 0, 1'b0);          // right angle
    queue_vertex(0, 0, 32'h8000_0000, 1'b0);
    queue_vertex(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b0);
    queue_vertex(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1'b1);
    queue_vertex(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0);
    queue_vertex(1, 0, 0, 1'b0);
    queue_vertex(32'hFFFF_FFFF, 1, 0, 1'b1);
    drain();

    // extreme references: saturation, the unused register index
    write_reg(REG_UNMAPPED, 32'hDEAD_BEEF);
    set_ref(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    queue_vertex(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b1);
    queue_vertex(1, 0, 0, 1'b0);
    queue_vertex(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1'b0);
    drain();
    set_ref(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    queue_vertex(32'h8000_0000, 0, 0, 1'b1);
    queue_vertex(0, 32'h0000_0001, 32'hFFFF_FFFF, 1'b0);
    drain();

    // random phases; idle profile changes every two phases
    for (int ph = 0; ph < 6; ph++) begin
      case (ph / 2)
        0: begin send_idle = 34; recv_idle = 79; end
        1: begin send_idle = 79; recv_idle = 34; end
        default: begin send_idle = 0; recv_idle = 0; end
      endcase
      case (ph)
        0: begin rx = 32'h0001_0000; ry = 32'h0001_0000; rz = 0; end
        1: begin rx = 32'h7FFF_FFFF; ry = 0; rz = 32'h8000_0000; end
        default: begin rx = rand_coord(); ry = rand_coord(); rz = rand_coord(); end
      endcase
      if (rx == 0 && ry == 0 && rz == 0) rx = 32'h0000_4000;
      set_ref(rx, ry, rz);
      // block fills and stalls its input during a long receiver hold-off
      if (ph == 4) hold_req = 1;
      for (int i = 0; i < 250; i++) queue_random();
      drain();
    end

    $display("Checked %0d results of %0d vertices over %0d reference settings;",
             n_recv, n_sent, 10);
    $display("%0d degenerate, %0d saturated, %0d mismatches.", n_deg, n_sat, errors);
    if (errors == 0 && arc_q.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
